>>> hdl/speed_command_curve_run_control_macros.svh
// Assertion macros for the speed command curve and run control block.
// Included by the top-level RTL file, which carries the concurrent assertions; no dependencies.
`ifndef SPEED_COMMAND_CURVE_RUN_CONTROL_MACROS_SVH
`define SPEED_COMMAND_CURVE_RUN_CONTROL_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/scc_pkg.sv
// Package for the speed command curve and run control block.
// Widths, register indexes, state types and the target saturation function.
`timescale 1ns / 1ps

package scc_pkg;

    localparam int SCC_NUM_POINTS = 6;
    localparam int SCC_NUM_CFG    = 6;
    localparam int SCC_LVL_W      = 16;
    localparam int SCC_PT_W       = 32;
    localparam int SCC_PROD_W     = 32;
    localparam int SCC_TGT_W      = 15;
    localparam int SCC_CFG_IDX_W  = 3;

    localparam logic [SCC_CFG_IDX_W-1:0] CFG_POINT_A = 3'd0;
    localparam logic [SCC_CFG_IDX_W-1:0] CFG_TOGGLE  = 3'd6;

    localparam logic [SCC_PT_W-1:0] SCC_PT_RESET [SCC_NUM_CFG] = '{
        32'd50, 32'd80, 32'd200, 32'd500, 32'd700, 32'd900
    };

    typedef logic [SCC_PT_W-1:0] t_bp;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_FAULT = 2'd2
    } t_sys_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_seq_state;

    typedef struct packed {
        logic fault;
        logic settled;
        logic sig_on;
        logic toggle_en;
    } t_run_req;

    typedef struct packed {
        t_sys_mode mode;
        logic      run;
        logic      clr;
    } t_run_rsp;

    function automatic logic [SCC_TGT_W-1:0] sat_target(input logic [SCC_LVL_W-1:0] t);
        sat_target = t[SCC_LVL_W-1] ? {SCC_TGT_W{1'b1}} : t[SCC_TGT_W-1:0];
    endfunction

endpackage

>>> hdl/scc_mac.sv
// Bit-serial multiply-accumulate: t0*a + t1*b, one multiplier bit per cycle, MSB first.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_mac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [scc_pkg::SCC_LVL_W-1:0]  i_a,
    input  logic [scc_pkg::SCC_LVL_W-1:0]  i_b,
    input  logic [scc_pkg::SCC_LVL_W-1:0]  i_t0,
    input  logic [scc_pkg::SCC_LVL_W-1:0]  i_t1,
    output logic                           o_done,
    output logic [scc_pkg::SCC_PROD_W-1:0] o_prod
);
    import scc_pkg::*;

    localparam int CNT_W = $clog2(SCC_LVL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCC_LVL_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SCC_LVL_W-1:0]  r_a;
    logic [SCC_LVL_W-1:0]  r_b;
    logic [SCC_LVL_W-1:0]  r_t0;
    logic [SCC_LVL_W-1:0]  r_t1;
    logic [SCC_PROD_W-1:0] r_acc;
    logic [SCC_PROD_W-1:0] n_acc;

    always_comb begin
        n_acc = {r_acc[SCC_PROD_W-2:0], 1'b0}
              + {{(SCC_PROD_W-SCC_LVL_W){1'b0}}, (r_a[SCC_LVL_W-1] ? r_t0 : '0)}
              + {{(SCC_PROD_W-SCC_LVL_W){1'b0}}, (r_b[SCC_LVL_W-1] ? r_t1 : '0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_t0  <= i_t0;
            r_t1  <= i_t1;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[SCC_LVL_W-2:0], 1'b0};
            r_b   <= {r_b[SCC_LVL_W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> hdl/scc_div.sv
// Restoring serial divider, one quotient bit per cycle; truncating quotient.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [scc_pkg::SCC_PROD_W-1:0] i_dividend,
    input  logic [scc_pkg::SCC_LVL_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [scc_pkg::SCC_LVL_W-1:0]  o_quo
);
    import scc_pkg::*;

    localparam int CNT_W = $clog2(SCC_PROD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCC_PROD_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SCC_LVL_W-1:0]  r_rem;
    logic [SCC_LVL_W-1:0]  r_dvs;
    logic [SCC_PROD_W-1:0] r_quo;
    logic [SCC_LVL_W:0]    w_trial;
    logic                  w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[SCC_PROD_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so its top trial bit drops out after subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? SCC_LVL_W'(w_trial - {1'b0, r_dvs}) : w_trial[SCC_LVL_W-1:0];
            r_quo <= {r_quo[SCC_PROD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[SCC_LVL_W-1:0];

endmodule

>>> hdl/scc_run_ctrl.sv
// Run control state machine (init, run, fault) with toggle fault clear.
// Depends on scc_pkg; steps once per transaction.
`timescale 1ns / 1ps

module scc_run_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  scc_pkg::t_run_req i_req,
    output scc_pkg::t_run_rsp o_rsp
);
    import scc_pkg::*;

    t_sys_mode r_mode;
    t_sys_mode n_mode;
    logic      r_reset_step;
    logic      n_reset_step;
    logic      w_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_INIT;
            r_reset_step <= 1'b0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_reset_step <= n_reset_step;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_reset_step = r_reset_step;
        w_clr        = 1'b0;
        unique case (r_mode)
            MODE_RUN: begin
                if (i_req.fault) begin
                    n_mode = MODE_FAULT;
                end
            end
            MODE_FAULT: begin
                if (!i_req.fault) begin
                    n_mode = MODE_RUN;
                end
                if (i_req.toggle_en) begin
                    if (!i_req.fault) begin
                        n_reset_step = 1'b0;
                    end
                    if (!i_req.sig_on && i_req.fault) begin
                        n_reset_step = 1'b1;
                    end
                    if (i_req.sig_on && n_reset_step) begin
                        n_reset_step = 1'b0;
                        w_clr        = 1'b1;
                    end
                end
            end
            default: begin
                n_mode = i_req.settled ? MODE_RUN : MODE_INIT;
            end
        endcase
    end

    assign o_rsp.mode = n_mode;
    assign o_rsp.run  = (r_mode == MODE_RUN) && !i_req.fault && i_req.sig_on;
    assign o_rsp.clr  = w_clr;

endmodule

>>> hdl/speed_command_curve_run_control.sv
// Acceptance to result in the output register: a command below breakpoint 1 goes
// straight to the output load; otherwise the walk steps one segment at a time, then,
// if the command falls inside a segment, the serial multiply and divide run before the load.
// One transaction at a time; the next is taken the cycle after the result is loaded.
// Synchronous active-low reset restores the breakpoint table, sets mode init and
// clears the signal-on flag.
`timescale 1ns / 1ps
`include "speed_command_curve_run_control_macros.svh"

module speed_command_curve_run_control #(
    parameter int NUM_POINTS = scc_pkg::SCC_NUM_POINTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [scc_pkg::SCC_LVL_W-1:0]     i_ctrl_sig,
    input  logic                              i_fault_active,
    input  logic                              i_power_settled,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [scc_pkg::SCC_TGT_W-1:0]     o_target,
    output logic                              o_sig_on,
    output logic                              o_run_enable,
    output logic [1:0]                        o_sys_state,
    output logic                              o_fault_clear,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scc_pkg::SCC_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [scc_pkg::SCC_PT_W-1:0]      i_cfg_data
);
    import scc_pkg::*;

    localparam int CHAIN_D = (NUM_POINTS > 2) ? NUM_POINTS - 1 : 2;
    localparam int LEFT_W  = $clog2(NUM_POINTS);
    localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(NUM_POINTS - 2);

    t_seq_state r_state;
    t_seq_state n_state;

    t_bp                  r_point [SCC_NUM_CFG];
    logic                 r_toggle;
    t_bp                  w_bp [CHAIN_D+1];
    t_bp                  r_chain [CHAIN_D];
    logic [LEFT_W-1:0]    r_left;
    logic [SCC_LVL_W-1:0] r_cmd;
    logic                 r_fault;
    logic                 r_settled;
    logic                 r_sig_on;
    logic [SCC_LVL_W-1:0] r_tgt;
    logic                 r_out_valid;

    logic                 w_accept;
    logic                 w_below0;
    logic                 w_below1;
    logic [SCC_LVL_W-1:0] w_c0;
    logic [SCC_LVL_W-1:0] w_t0;
    logic [SCC_LVL_W-1:0] w_c1;
    logic [SCC_LVL_W-1:0] w_t1;
    logic                 w_walk_end;
    logic                 w_walk_hit;
    logic                 w_mac_start;
    logic                 w_div_start;
    logic                 w_step;
    logic                 w_mac_done;
    logic                 w_div_done;
    logic [SCC_PROD_W-1:0] w_prod;
    logic [SCC_LVL_W-1:0] w_quo;
    t_run_req             w_req;
    t_run_rsp             w_rsp;

    genvar g;
    generate
        for (g = 0; g <= CHAIN_D; g++) begin : g_bp
            if (g < SCC_NUM_CFG && g < NUM_POINTS) begin : g_reg
                assign w_bp[g] = r_point[g];
            end else begin : g_zero
                assign w_bp[g] = '0;
            end
        end
    endgenerate

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_below0    = i_ctrl_sig < w_bp[0][SCC_LVL_W-1:0];
    assign w_below1    = i_ctrl_sig < w_bp[1][SCC_LVL_W-1:0];
    assign w_c0        = r_chain[0][SCC_LVL_W-1:0];
    assign w_t0        = r_chain[0][SCC_PT_W-1:SCC_LVL_W];
    assign w_c1        = r_chain[1][SCC_LVL_W-1:0];
    assign w_t1        = r_chain[1][SCC_PT_W-1:SCC_LVL_W];
    assign w_walk_end  = (r_left == '0) || (w_c0 > w_c1);
    assign w_walk_hit  = r_cmd < w_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point  <= SCC_PT_RESET;
            r_toggle <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index < CFG_TOGGLE) begin
                r_point[i_cfg_index] <= i_cfg_data;
            end else if (i_cfg_index == CFG_TOGGLE) begin
                r_toggle <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        w_mac_start = 1'b0;
        w_div_start = 1'b0;
        w_step      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = (w_below0 || w_below1) ? ST_FIN : ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_walk_end) begin
                    n_state = ST_FIN;
                end else if (w_walk_hit) begin
                    w_mac_start = 1'b1;
                    n_state     = ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_mac_done) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_step  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_on <= 1'b0;
        end else if (w_accept) begin
            if (w_below0) begin
                r_sig_on <= 1'b0;
            end else if (!w_below1) begin
                r_sig_on <= 1'b1;
            end
        end
    end

    // breakpoints 1.. shift down one place per walked segment
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_ctrl_sig;
            r_fault   <= i_fault_active;
            r_settled <= i_power_settled;
            r_tgt     <= w_below0 ? '0 : w_bp[1][SCC_PT_W-1:SCC_LVL_W];
            r_left    <= LEFT_INIT;
            for (int k = 0; k < CHAIN_D; k++) begin
                r_chain[k] <= w_bp[k+1];
            end
        end else if (r_state == ST_WALK) begin
            if (w_walk_end) begin
                r_tgt <= w_t0;
            end else if (!w_walk_hit) begin
                r_left <= r_left - 1'b1;
                for (int k = 0; k < CHAIN_D - 1; k++) begin
                    r_chain[k] <= r_chain[k+1];
                end
                r_chain[CHAIN_D-1] <= '0;
            end
        end else if (r_state == ST_DIV && w_div_done) begin
            r_tgt <= w_quo;
        end
    end

    scc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_start),
        .i_a     (w_c1 - r_cmd),
        .i_b     (r_cmd - w_c0),
        .i_t0    (w_t0),
        .i_t1    (w_t1),
        .o_done  (w_mac_done),
        .o_prod  (w_prod)
    );

    scc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (w_c1 - w_c0),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    assign w_req.fault     = r_fault;
    assign w_req.settled   = r_settled;
    assign w_req.sig_on    = r_sig_on;
    assign w_req.toggle_en = r_toggle;

    scc_run_ctrl u_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            o_target      <= sat_target(r_tgt);
            o_sig_on      <= r_sig_on;
            o_run_enable  <= w_rsp.run;
            o_sys_state   <= w_rsp.mode;
            o_fault_clear <= w_rsp.clr;
        end
    end

    assign o_out_valid = r_out_valid;

    `SCC_ASSERT_IMP(a_mac_done_in_mul, i_clk, i_rst_n, w_mac_done, r_state == ST_MUL, "multiply finished outside multiply phase")
    `SCC_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == ST_DIV, "divide finished outside divide phase")
    `SCC_ASSERT_IMP(a_run_in_run_mode, i_clk, i_rst_n, o_out_valid && o_run_enable, o_sig_on && (o_sys_state == MODE_RUN), "run enable without run mode and signal on")
    `SCC_ASSERT_IMP(a_clr_in_fault, i_clk, i_rst_n, o_out_valid && o_fault_clear, o_sys_state == MODE_FAULT, "fault clear pulse outside fault mode")
    `SCC_ASSERT_NXT(a_step_loads_out, i_clk, i_rst_n, w_step, o_out_valid && (r_state == ST_IDLE), "finished transaction not presented")

endmodule

>>> bench/testbench.sv
// Self-checking bench for speed_command_curve_run_control: a queue-fed driver, a monitor
// with a built-in predictor of the curve and run state machine, config phases and a watchdog.
// Depends on scc_pkg and the block RTL only.
`timescale 1ns / 1ps

module testbench;
    import scc_pkg::*;

    localparam int NPTS       = SCC_NUM_POINTS;
    localparam int HALF_CLK   = 2;
    localparam int RST_CYCLES = 10;
    localparam int RX_HOLD    = 400;
    localparam int QUIET_MAX  = 3000;
    localparam int PHASE_TICKS = 104;
    localparam logic [SCC_CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic [SCC_LVL_W-1:0] cmd;
        logic                 fault;
        logic                 settled;
    } t_tick;

    typedef struct packed {
        logic [SCC_TGT_W-1:0] target;
        logic                 sig_on;
        logic                 run;
        t_sys_mode            mode;
        logic                 clr;
    } t_tick_rsp;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [SCC_LVL_W-1:0]     i_ctrl_sig = '0;
    logic                     i_fault_active = 1'b0;
    logic                     i_power_settled = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [SCC_TGT_W-1:0]     o_target;
    logic                     o_sig_on;
    logic                     o_run_enable;
    logic [1:0]               o_sys_state;
    logic                     o_fault_clear;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [SCC_CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SCC_PT_W-1:0]      i_cfg_data = '0;

    // predictor state
    t_bp       m_bp [8];
    logic      m_toggle;
    logic      m_sig_on;
    t_sys_mode m_mode;
    logic      m_rst_step;

    t_tick     tick_pend_q [$];
    t_tick_rsp ctrl_rsp_expect_q [$];
    int        n_queued = 0;
    int        n_acc = 0;
    int        n_err = 0;
    int        quiet = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        hold_left = 0;
    logic      rx_hold_go = 1'b0;
    logic      in_taken = 1'b0;
    logic      gen_fault = 1'b0;

    speed_command_curve_run_control DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_ctrl_sig      (i_ctrl_sig),
        .i_fault_active  (i_fault_active),
        .i_power_settled (i_power_settled),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_target        (o_target),
        .o_sig_on        (o_sig_on),
        .o_run_enable    (o_run_enable),
        .o_sys_state     (o_sys_state),
        .o_fault_clear   (o_fault_clear),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(HALF_CLK) i_clk = ~i_clk;

    function automatic t_tick_rsp predict_tick(input t_tick it);
        t_tick_rsp r;
        longint    lvl, c0, c1, t0, t1, num, tv;
        int        k;
        bit        done;
        r = '0;
        tv = 0;
        done = 0;
        lvl = it.cmd;
        if (lvl < m_bp[0][15:0]) begin
            m_sig_on = 1'b0;
        end else if (lvl < m_bp[1][15:0]) begin
            tv = m_bp[1][31:16];
        end else begin
            m_sig_on = 1'b1;
            for (k = 1; k < NPTS && !done; k++) begin
                c0 = m_bp[k][15:0];
                t0 = m_bp[k][31:16];
                if (k == NPTS - 1) begin
                    tv = t0;
                    done = 1;
                end else begin
                    c1 = m_bp[k+1][15:0];
                    t1 = m_bp[k+1][31:16];
                    if (c0 > c1) begin
                        tv = t0;
                        done = 1;
                    end else if (lvl < c1) begin
                        num = t0 * (c1 - c0) + (t1 - t0) * (lvl - c0);
                        if (num < 0) num = 0;
                        tv = num / (c1 - c0);
                        done = 1;
                    end
                end
            end
        end
        r.target = (tv > 32767) ? {SCC_TGT_W{1'b1}} : tv[SCC_TGT_W-1:0];
        r.run = (m_mode == MODE_RUN) && !it.fault && m_sig_on;
        case (m_mode)
            MODE_RUN: begin
                if (it.fault) m_mode = MODE_FAULT;
            end
            MODE_FAULT: begin
                if (!it.fault) m_mode = MODE_RUN;
                if (m_toggle) begin
                    if (!it.fault) m_rst_step = 1'b0;
                    if (!m_sig_on && it.fault) m_rst_step = 1'b1;
                    if (m_sig_on && m_rst_step) begin
                        m_rst_step = 1'b0;
                        r.clr = 1'b1;
                    end
                end
            end
            default: m_mode = it.settled ? MODE_RUN : MODE_INIT;
        endcase
        r.sig_on = m_sig_on;
        r.mode = m_mode;
        return r;
    endfunction

    function automatic logic [SCC_LVL_W-1:0] pick_cmd();
        int unsigned sel, lo, hi;
        int          v;
        sel = $urandom_range(99);
        lo = m_bp[0][15:0];
        hi = m_bp[1][15:0];
        if (sel < 20 && lo > 0) return SCC_LVL_W'($urandom_range(lo - 1, 0));
        if (sel < 35 && hi > lo) return SCC_LVL_W'($urandom_range(hi - 1, lo));
        if (sel < 50) begin
            v = int'(m_bp[$urandom_range(NPTS - 1)][15:0]) + int'($urandom_range(2)) - 1;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return SCC_LVL_W'(v);
        end
        lo = m_bp[1][15:0];
        hi = m_bp[NPTS-1][15:0];
        if (sel < 88 && hi > lo) return SCC_LVL_W'($urandom_range(hi, lo));
        return SCC_LVL_W'($urandom);
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_err++;
        end
    endtask

    // monitor: output check first, then prediction of the transaction taken at this edge
    always @(posedge i_clk) begin : mon
        t_tick_rsp want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (ctrl_rsp_expect_q.size() == 0) begin
                    $display("%0t ns: result with none expected, target %0d", $time, o_target);
                    n_err++;
                end else begin
                    want = ctrl_rsp_expect_q.pop_front();
                    check_field("target", want.target, o_target);
                    check_field("sig_on", want.sig_on, o_sig_on);
                    check_field("run_enable", want.run, o_run_enable);
                    check_field("sys_state", want.mode, o_sys_state);
                    check_field("fault_clear", want.clr, o_fault_clear);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                ctrl_rsp_expect_q.push_back(
                    predict_tick('{i_ctrl_sig, i_fault_active, i_power_settled}));
                n_acc++;
                in_taken = 1'b1;
            end else begin
                in_taken = 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drv
        t_tick nx;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (tick_pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nx = tick_pend_q.pop_front();
                i_in_valid <= 1'b1;
                i_ctrl_sig <= nx.cmd;
                i_fault_active <= nx.fault;
                i_power_settled <= nx.settled;
            end else begin
                i_in_valid <= 1'b0;
                i_ctrl_sig <= SCC_LVL_W'($urandom);
            end
        end
    end

    always @(negedge i_clk) begin : rx
        if (rx_hold_go) begin
            hold_left = RX_HOLD;
            rx_hold_go = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic cfg_write(input logic [SCC_CFG_IDX_W-1:0] idx, input t_bp data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < SCC_NUM_CFG) m_bp[idx] = data;
        else if (idx == CFG_TOGGLE) m_toggle = data[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_table(input t_bp p0, p1, p2, p3, p4, p5, input logic tog);
        t_bp pts [SCC_NUM_CFG];
        int  k;
        pts[0] = p0;
        pts[1] = p1;
        pts[2] = p2;
        pts[3] = p3;
        pts[4] = p4;
        pts[5] = p5;
        cfg_write(CFG_SPARE, $urandom);
        for (k = 0; k < SCC_NUM_CFG; k++)
            cfg_write(CFG_POINT_A + SCC_CFG_IDX_W'(k), pts[k]);
        cfg_write(CFG_TOGGLE, {31'($urandom), tog});
    endtask

    task automatic load_random_table();
        int unsigned lv [$];
        t_bp         p [SCC_NUM_CFG];
        int          k;
        repeat (SCC_NUM_CFG) lv.push_back($urandom_range(16'hFFFF));
        if ($urandom_range(3) != 0) lv.sort();
        for (k = 0; k < SCC_NUM_CFG; k++) p[k] = {16'($urandom), 16'(lv[k])};
        load_table(p[0], p[1], p[2], p[3], p[4], p[5], 1'($urandom_range(1)));
    endtask

    task automatic add_tick(input logic [SCC_LVL_W-1:0] cmd, input logic fault,
                            input logic settled);
        tick_pend_q.push_back('{cmd, fault, settled});
        n_queued++;
    endtask

    task automatic add_random_ticks(input int n);
        repeat (n) begin
            if ($urandom_range(99) < 10) gen_fault = !gen_fault;
            add_tick(pick_cmd(), gen_fault, $urandom_range(99) < 92);
        end
    endtask

    task automatic drain();
        while (n_acc != n_queued || ctrl_rsp_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : seq
        int ph;
        for (ph = 0; ph < SCC_NUM_CFG; ph++) m_bp[ph] = SCC_PT_RESET[ph];
        m_bp[6] = '0;
        m_bp[7] = '0;
        m_toggle = 1'b1;
        m_sig_on = 1'b0;
        m_mode = MODE_INIT;
        m_rst_step = 1'b0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset table
        add_tick(16'd0, 1'b0, 1'b0);
        add_tick(16'd80, 1'b0, 1'b1);
        add_tick(16'hFFFF, 1'b0, 1'b1);
        drain();

        // steep curve, top segment saturates
        load_table({16'hFFFF, 16'd1000}, {16'd2000, 16'd3000}, {16'd8000, 16'd10000},
                   {16'd16000, 16'd20000}, {16'd30000, 16'd40000},
                   {16'd50000, 16'd60000}, 1'b1);
        add_tick(16'd0, 1'b0, 1'b0);
        add_tick(16'hFFFF, 1'b0, 1'b0);
        add_tick(16'd2000, 1'b0, 1'b1);
        add_tick(16'd3000, 1'b0, 1'b1);
        add_tick(16'd999, 1'b0, 1'b1);
        add_tick(16'd1000, 1'b0, 1'b1);
        add_tick(16'd6500, 1'b0, 1'b1);
        add_tick(16'd10000, 1'b0, 1'b1);
        add_tick(16'd59999, 1'b0, 1'b1);
        add_tick(16'd25000, 1'b1, 1'b1);
        add_tick(16'd500, 1'b1, 1'b1);
        add_tick(16'd15000, 1'b1, 1'b1);
        add_tick(16'd15000, 1'b1, 1'b1);
        add_tick(16'd15000, 1'b0, 1'b1);
        add_tick(16'd15000, 1'b0, 1'b0);
        add_tick(16'd2500, 1'b0, 1'b1);
        add_tick(16'd500, 1'b1, 1'b1);
        add_tick(16'd500, 1'b0, 1'b1);
        add_tick(16'hFFFF, 1'b1, 1'b0);
        drain();

        // drop and reapply with fault clear disabled
        cfg_write(CFG_TOGGLE, '0);
        add_tick(16'd100, 1'b1, 1'b1);
        add_tick(16'd20000, 1'b1, 1'b1);
        add_tick(16'd20000, 1'b0, 1'b1);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_table(SCC_PT_RESET[0], SCC_PT_RESET[1], SCC_PT_RESET[2],
                              SCC_PT_RESET[3], SCC_PT_RESET[4], SCC_PT_RESET[5], 1'b1);
                1: load_table({16'd0, 16'd1000}, {16'd1000, 16'd3000},
                              {16'd6000, 16'd9000}, {16'd12000, 16'd20000},
                              {16'd20000, 16'd35000}, {16'd32767, 16'd60000}, 1'b1);
                2: load_table('1, '1, '1, '1, '1, '1, 1'b0);
                3: load_table(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                              32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b1);
                4: load_table({16'd7, 16'd100}, {16'd40000, 16'd2000},
                              {16'd123, 16'd2000}, {16'd65535, 16'd30000},
                              {16'd900, 16'd10000}, {16'd5000, 16'd50000}, 1'b0);
                default: load_random_table();
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
                default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
            endcase
            add_random_ticks(PHASE_TICKS);
            if (ph == 0) rx_hold_go = 1'b1;
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (n_err == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/scc_pkg.sv
hdl/scc_mac.sv
hdl/scc_div.sv
hdl/scc_run_ctrl.sv
hdl/speed_command_curve_run_control.sv
bench/testbench.sv
